[sv/arcrot_pkg.sv]
// ----------------------------------------------------------------------------
// arcrot_pkg: shared constants and types of the arcball rotation block
// Fixed-point formats, unit widths, the arctangent table and config indexes.
// ----------------------------------------------------------------------------
package arcrot_pkg;

  localparam int FRAC_BITS   = 14;
  localparam int CURSOR_BITS = 14;
  localparam int COORD_W     = 16;
  localparam int SIZE_W      = 13;

  localparam int ONE_Q  = 1 << FRAC_BITS;
  localparam int ONE_SQ = 1 << (2 * FRAC_BITS);

  // Restoring divider: 29-bit dividend, 15-bit divisor, 15 quotient bits.
  localparam int DIV_NUM_W = 29;
  localparam int DIV_DEN_W = 15;
  localparam int DIV_Q_W   = 15;
  localparam int DIV_LAT   = DIV_Q_W + 1;

  // Square-square products and the integer square root.
  localparam int SQ_W        = 29;
  localparam int SQRT_IN_W   = 30;
  localparam int SQRT_OUT_W  = 15;
  localparam int SQRT_LAT    = SQRT_OUT_W;

  // CORDIC in Q30.
  localparam int Q30_BITS     = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 34;
  localparam int ANG_SHIFT    = Q30_BITS - FRAC_BITS;
  localparam longint EPS_Q30     = 1073742;
  localparam longint HALF_PI_Q30 = 1686629713;
  localparam longint EPS_Q = (EPS_Q30 + (longint'(1) << (ANG_SHIFT - 1))) >> ANG_SHIFT;

  localparam logic [Q30_BITS-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
    30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
    30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
    30'd32,        30'd16,        30'd8,         30'd4,         30'd2
  };

  // Configuration register indexes and reset values.
  localparam logic [0:0] CFG_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_HEIGHT = 1'b1;
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd1024;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd768;

  typedef logic signed [COORD_W-1:0] coord_t;

  // One lifted point travelling beside the square-root unit.
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   in_ball;
  } pt_side_t;

  // One lifted point travelling beside the rim-normalising dividers.
  typedef struct packed {
    coord_t                x;
    coord_t                y;
    logic [SQRT_OUT_W-1:0] root;
    logic                  in_ball;
  } lift_side_t;

endpackage

[sv/arcrot_div.sv]
// ----------------------------------------------------------------------------
// arcrot_div: pipelined restoring divider
// One quotient bit per stage; flags a quotient that would not fit.
// ----------------------------------------------------------------------------
module arcrot_div import arcrot_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_Q_W-1:0]   quo,
  output logic                 sat
);

  logic [DIV_NUM_W-1:0] r_s [DIV_LAT];
  logic [DIV_DEN_W-1:0] d_s [DIV_LAT];
  logic [DIV_Q_W-1:0]   q_s [DIV_LAT];
  logic                 s_s [DIV_LAT];

  logic [DIV_NUM_W:0]   dsh [DIV_LAT];
  logic                 ge  [DIV_LAT];
  logic [DIV_NUM_W-1:0] rn  [DIV_LAT];

  always_comb begin
    dsh[0] = '0;
    ge[0]  = 1'b0;
    rn[0]  = '0;
    for (int k = 1; k < DIV_LAT; k++) begin
      dsh[k] = {(DIV_NUM_W + 1 - DIV_DEN_W)'(0), d_s[k-1]} << (DIV_Q_W - k);
      ge[k]  = {1'b0, r_s[k-1]} >= dsh[k];
      rn[k]  = ge[k] ? DIV_NUM_W'({1'b0, r_s[k-1]} - dsh[k]) : r_s[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_s[0] <= num;
      d_s[0] <= den;
      q_s[0] <= '0;
      s_s[0] <= {1'b0, num} >= {den, (DIV_NUM_W + 1 - DIV_DEN_W)'(0)};
      for (int k = 1; k < DIV_LAT; k++) begin
        r_s[k] <= rn[k];
        d_s[k] <= d_s[k-1];
        q_s[k] <= {q_s[k-1][DIV_Q_W-2:0], ge[k]};
        s_s[k] <= s_s[k-1];
      end
    end
  end

  assign quo = q_s[DIV_LAT-1];
  assign sat = s_s[DIV_LAT-1];

endmodule

[sv/arcrot_sqrt.sv]
// ----------------------------------------------------------------------------
// arcrot_sqrt: pipelined integer square root
// Digit-by-digit floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module arcrot_sqrt import arcrot_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [SQRT_IN_W-1:0]  arg,
  output logic [SQRT_OUT_W-1:0] root
);

  logic [SQRT_IN_W:0] v_s [SQRT_LAT];
  logic [SQRT_IN_W:0] r_s [SQRT_LAT];
  logic [SQRT_IN_W:0] vi  [SQRT_LAT];
  logic [SQRT_IN_W:0] ri  [SQRT_LAT];
  logic [SQRT_IN_W:0] bt  [SQRT_LAT];
  logic [SQRT_IN_W:0] tr  [SQRT_LAT];
  logic               ge  [SQRT_LAT];

  always_comb begin
    for (int k = 0; k < SQRT_LAT; k++) begin
      vi[k] = (k == 0) ? {1'b0, arg} : v_s[(k == 0) ? 0 : k - 1];
      ri[k] = (k == 0) ? '0 : r_s[(k == 0) ? 0 : k - 1];
      bt[k] = (SQRT_IN_W + 1)'(1) << (2 * (SQRT_OUT_W - 1 - k));
      tr[k] = ri[k] + bt[k];
      ge[k] = vi[k] >= tr[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_LAT; k++) begin
        v_s[k] <= ge[k] ? vi[k] - tr[k] : vi[k];
        r_s[k] <= ge[k] ? (ri[k] >> 1) + bt[k] : ri[k] >> 1;
      end
    end
  end

  assign root = r_s[SQRT_LAT-1][SQRT_OUT_W-1:0];

endmodule

[sv/arcball_rotation.sv]
// ----------------------------------------------------------------------------
// arcball_rotation: arcball drag to rotation axis and angle
// Maps a drag start and end cursor position onto the unit sphere and returns
// the rotation angle (acos of the dot product) and the cross-product axis.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+------------------------------------
//   cfg      | cfg_valid / cfg_ready        | cfg_index, cfg_data
//   item     | item_valid / item_stall      | start_x, start_y, end_x, end_y
//   result   | result_valid / result_stall  | rotation_valid, axis_x/y/z, angle
//
// A drag pair may be transferred on every clock that item_stall is low, and each
// one yields one result after it has passed this chain of units in turn:
// two 16-stage dividers, two 15-stage square roots and a 30-stage CORDIC.
// All stages advance together whenever the output register is empty or its
// result is being transferred, so a stall holds every stage and loses nothing.
// Reset (rst, synchronous) clears the stage valid bits and restores the window
// size registers; the arithmetic registers are not reset.
//
module arcball_rotation import arcrot_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [0:0]                    cfg_index,
  input  logic [SIZE_W-1:0]             cfg_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic signed [CURSOR_BITS-1:0] start_x,
  input  logic signed [CURSOR_BITS-1:0] start_y,
  input  logic signed [CURSOR_BITS-1:0] end_x,
  input  logic signed [CURSOR_BITS-1:0] end_y,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          rotation_valid,
  output coord_t                        axis_x,
  output coord_t                        axis_y,
  output coord_t                        axis_z,
  output logic [COORD_W-1:0]            angle
);

  // Stage numbering: stage 1 is the first divider register, stage 101 the
  // last CORDIC step, and the output register follows it.
  localparam int LAST_STG  = 2 * DIV_LAT + 2 * SQRT_LAT + CORDIC_STEPS + 9;
  localparam int CROSS_DLY = LAST_STG - (DIV_LAT * 2 + SQRT_LAT + 6);

  localparam coord_t ONE_C = coord_t'(ONE_Q);

  // --------------------------------------------------------------------------
  // Configuration registers. The user writes only while block is idle; unchecked.
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0] win_width;
  logic [SIZE_W-1:0] win_height;
  logic [SIZE_W-1:0] wsz;
  logic [SIZE_W-1:0] hsz;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_width  <= WIDTH_RESET;
      win_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH:  win_width  <= cfg_data;
        CFG_HEIGHT: win_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero window size behaves as a size of one pixel.
  assign wsz = (win_width == '0) ? SIZE_W'(1) : win_width;
  assign hsz = (win_height == '0) ? SIZE_W'(1) : win_height;

  // --------------------------------------------------------------------------
  // Pipeline advance and the valid bits that travel with the data.
  // --------------------------------------------------------------------------
  logic                adv;
  logic [LAST_STG:1]   vld;

  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST_STG-1:1], item_valid};
    end
  end

  // --------------------------------------------------------------------------
  // Device coordinates. Lanes 0..3 are start x, start y, end x, end y. The
  // dividend already holds half the divisor so the quotient rounds half away.
  // --------------------------------------------------------------------------
  logic signed [CURSOR_BITS-1:0] cur    [4];
  logic [CURSOR_BITS-1:0]        mag_l  [4];
  logic [SIZE_W-1:0]             size_l [4];
  logic [DIV_NUM_W-1:0]          dnum1  [4];
  logic [DIV_DEN_W-1:0]          dden1  [4];
  logic [DIV_Q_W-1:0]            dq1    [4];
  logic                          dsat1  [4];
  logic [3:0]                    neg_in;
  logic [3:0]                    neg_d  [DIV_LAT];

  assign cur[0] = start_x;
  assign cur[1] = start_y;
  assign cur[2] = end_x;
  assign cur[3] = end_y;

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      mag_l[g]  = cur[g][CURSOR_BITS-1] ? CURSOR_BITS'(-cur[g]) : CURSOR_BITS'(cur[g]);
      size_l[g] = (g == 1 || g == 3) ? hsz : wsz;
      dnum1[g]  = (DIV_NUM_W'(mag_l[g]) << (FRAC_BITS + 1)) + DIV_NUM_W'(size_l[g] >> 1);
      dden1[g]  = DIV_DEN_W'(size_l[g]);
      neg_in[g] = cur[g][CURSOR_BITS-1];
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_ndc_div
    arcrot_div u_div (
      .clk (clk),
      .en  (adv),
      .num (dnum1[g]),
      .den (dden1[g]),
      .quo (dq1[g]),
      .sat (dsat1[g])
    );
  end

  // --------------------------------------------------------------------------
  // Clamp to [-1, 1] and flip y; then square and sum for the sphere test.
  // A negative cursor position always lands at -1 before the flip.
  // --------------------------------------------------------------------------
  coord_t               ndc_raw [4];
  coord_t               ndc     [4];
  coord_t               ndc_c   [4];
  logic signed [31:0]   sq_p    [4];
  logic [SQ_W-1:0]      sq      [4];
  logic [SQRT_IN_W-1:0] csum    [2];
  logic [SQRT_IN_W-1:0] arg1    [2];
  logic                 in_d    [2];
  coord_t               ndc_d   [4];
  pt_side_t             ls_in   [2];
  pt_side_t             ls_d    [SQRT_LAT][2];
  logic [SQRT_OUT_W-1:0] root1  [2];

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      if (neg_d[DIV_LAT-1][g]) begin
        ndc_raw[g] = -ONE_C;
      end else if (dsat1[g]) begin
        ndc_raw[g] = ONE_C;
      end else begin
        ndc_raw[g] = coord_t'({1'b0, dq1[g]}) - ONE_C;
      end
      sq_p[g] = ndc[g] * ndc[g];
    end
    for (int p = 0; p < 2; p++) begin
      csum[p] = SQRT_IN_W'(sq[2*p]) + SQRT_IN_W'(sq[2*p+1]);
      ls_in[p].x       = ndc_d[2*p];
      ls_in[p].y       = ndc_d[2*p+1];
      ls_in[p].in_ball = in_d[p];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_d[0] <= neg_in;
      for (int k = 1; k < DIV_LAT; k++) begin
        neg_d[k] <= neg_d[k-1];
      end
      for (int g = 0; g < 4; g++) begin
        ndc[g]   <= (g == 1 || g == 3) ? -ndc_raw[g] : ndc_raw[g];
        sq[g]    <= sq_p[g][SQ_W-1:0];
        ndc_c[g] <= ndc[g];
        ndc_d[g] <= ndc_c[g];
      end
      for (int p = 0; p < 2; p++) begin
        in_d[p] <= csum[p] <= SQRT_IN_W'(ONE_SQ);
        arg1[p] <= (csum[p] <= SQRT_IN_W'(ONE_SQ)) ? SQRT_IN_W'(ONE_SQ) - csum[p]
                                                      : csum[p];
        ls_d[0][p] <= ls_in[p];
        for (int k = 1; k < SQRT_LAT; k++) begin
          ls_d[k][p] <= ls_d[k-1][p];
        end
      end
    end
  end

  // Inside the ball the root is z; outside it is the length used to pull the
  // point back onto the rim.
  for (genvar p = 0; p < 2; p++) begin : g_lift_sqrt
    arcrot_sqrt u_sqrt (
      .clk  (clk),
      .en   (adv),
      .arg  (arg1[p]),
      .root (root1[p])
    );
  end

  // --------------------------------------------------------------------------
  // Rim normalisation: lanes 0..3 are start x, start y, end x, end y.
  // --------------------------------------------------------------------------
  coord_t                 lv     [4];
  logic [COORD_W-2:0]     lmag   [4];
  logic [DIV_NUM_W-1:0]   dnum2  [4];
  logic [DIV_DEN_W-1:0]   dden2  [4];
  logic [DIV_Q_W-1:0]     dq2    [4];
  logic                   dsat2  [4];
  lift_side_t             s2_in  [2];
  lift_side_t             s2_d   [DIV_LAT][2];
  coord_t                 rim    [4];
  coord_t                 vec_n  [6];
  coord_t                 vec    [6];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      lv[l]    = (l == 1 || l == 3) ? ls_d[SQRT_LAT-1][l/2].y : ls_d[SQRT_LAT-1][l/2].x;
      lmag[l]  = lv[l][COORD_W-1] ? (COORD_W-1)'(-lv[l]) : (COORD_W-1)'(lv[l]);
      dnum2[l] = (DIV_NUM_W'(lmag[l]) << FRAC_BITS) + DIV_NUM_W'(root1[l/2] >> 1);
      dden2[l] = DIV_DEN_W'(root1[l/2]);
    end
    for (int p = 0; p < 2; p++) begin
      s2_in[p].x       = ls_d[SQRT_LAT-1][p].x;
      s2_in[p].y       = ls_d[SQRT_LAT-1][p].y;
      s2_in[p].root    = root1[p];
      s2_in[p].in_ball = ls_d[SQRT_LAT-1][p].in_ball;
    end
    for (int l = 0; l < 4; l++) begin
      if (dsat2[l] || ({1'b0, dq2[l]} > COORD_W'(ONE_Q))) begin
        rim[l] = ONE_C;
      end else begin
        rim[l] = coord_t'({1'b0, dq2[l]});
      end
      if ((l == 1 || l == 3) ? s2_d[DIV_LAT-1][l/2].y[COORD_W-1]
                             : s2_d[DIV_LAT-1][l/2].x[COORD_W-1]) begin
        rim[l] = -rim[l];
      end
    end
    for (int p = 0; p < 2; p++) begin
      if (s2_d[DIV_LAT-1][p].in_ball) begin
        vec_n[3*p]   = s2_d[DIV_LAT-1][p].x;
        vec_n[3*p+1] = s2_d[DIV_LAT-1][p].y;
        vec_n[3*p+2] = coord_t'({1'b0, s2_d[DIV_LAT-1][p].root});
      end else begin
        vec_n[3*p]   = rim[2*p];
        vec_n[3*p+1] = rim[2*p+1];
        vec_n[3*p+2] = '0;
      end
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_rim_div
    arcrot_div u_div (
      .clk (clk),
      .en  (adv),
      .num (dnum2[l]),
      .den (dden2[l]),
      .quo (dq2[l]),
      .sat (dsat2[l])
    );
  end

  // --------------------------------------------------------------------------
  // Dot and cross products. vec[0..2] is the start point, vec[3..5] the end.
  // --------------------------------------------------------------------------
  logic signed [31:0] pr_n [9];
  logic signed [31:0] pr   [9];
  logic signed [31:0] dsum;
  logic signed [31:0] drnd;
  logic signed [31:0] xr   [3];
  coord_t             d_n;
  coord_t             d_h;
  coord_t             cross_h [3];
  coord_t             cross_d [CROSS_DLY][3];
  logic signed [31:0] dd_p;
  logic [SQ_W-1:0]    dd;
  coord_t             d_i;
  coord_t             d_j;
  logic [SQRT_IN_W-1:0] arg2;
  logic [SQRT_OUT_W-1:0] root2;
  coord_t             d_q [SQRT_LAT];

  always_comb begin
    pr_n[0] = vec[0] * vec[3];
    pr_n[1] = vec[1] * vec[4];
    pr_n[2] = vec[2] * vec[5];
    pr_n[3] = vec[1] * vec[5];
    pr_n[4] = vec[2] * vec[4];
    pr_n[5] = vec[2] * vec[3];
    pr_n[6] = vec[0] * vec[5];
    pr_n[7] = vec[0] * vec[4];
    pr_n[8] = vec[1] * vec[3];
    dsum = pr[0] + pr[1] + pr[2];
    drnd = (dsum + 32'sd8192) >>> FRAC_BITS;
    if (drnd > 32'(ONE_Q)) begin
      d_n = ONE_C;
    end else if (drnd < -32'(ONE_Q)) begin
      d_n = -ONE_C;
    end else begin
      d_n = coord_t'(drnd);
    end
    xr[0] = (pr[3] - pr[4] + 32'sd8192) >>> FRAC_BITS;
    xr[1] = (pr[5] - pr[6] + 32'sd8192) >>> FRAC_BITS;
    xr[2] = (pr[7] - pr[8] + 32'sd8192) >>> FRAC_BITS;
    dd_p = d_h * d_h;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vec <= vec_n;
      for (int p = 0; p < 2; p++) begin
        s2_d[0][p] <= s2_in[p];
        for (int k = 1; k < DIV_LAT; k++) begin
          s2_d[k][p] <= s2_d[k-1][p];
        end
      end
      pr  <= pr_n;
      d_h <= d_n;
      for (int c = 0; c < 3; c++) begin
        cross_h[c]    <= xr[c][COORD_W-1:0];
        cross_d[0][c] <= cross_h[c];
        for (int k = 1; k < CROSS_DLY; k++) begin
          cross_d[k][c] <= cross_d[k-1][c];
        end
      end
      dd   <= dd_p[SQ_W-1:0];
      d_i  <= d_h;
      arg2 <= SQRT_IN_W'(ONE_SQ) - SQRT_IN_W'(dd);
      d_j  <= d_i;
      d_q[0] <= d_j;
      for (int k = 1; k < SQRT_LAT; k++) begin
        d_q[k] <= d_q[k-1];
      end
    end
  end

  // Sine of the angle, from sqrt(1 - d*d).
  arcrot_sqrt u_sin_sqrt (
    .clk  (clk),
    .en   (adv),
    .arg  (arg2),
    .root (root2)
  );

  // --------------------------------------------------------------------------
  // Vectoring CORDIC for atan2(sin, cos) in Q30, with a quarter-turn
  // prerotation when the cosine is negative.
  // --------------------------------------------------------------------------
  logic signed [CORDIC_W-1:0] x0;
  logic signed [CORDIC_W-1:0] y0;
  logic signed [CORDIC_W-1:0] cx [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] cy [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] cz [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] nx [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] ny [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] nz [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] at [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] zr;
  logic [COORD_W-1:0]         ang;
  logic                       rot;

  always_comb begin
    x0 = CORDIC_W'(d_q[SQRT_LAT-1]) <<< ANG_SHIFT;
    y0 = CORDIC_W'({1'b0, root2}) <<< ANG_SHIFT;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      at[i] = CORDIC_W'({1'b0, ATAN_TAB[i]});
      if (!cy[i][CORDIC_W-1]) begin
        nx[i] = cx[i] + (cy[i] >>> i);
        ny[i] = cy[i] - (cx[i] >>> i);
        nz[i] = cz[i] + at[i];
      end else begin
        nx[i] = cx[i] - (cy[i] >>> i);
        ny[i] = cy[i] + (cx[i] >>> i);
        nz[i] = cz[i] - at[i];
      end
    end
    zr  = (cz[CORDIC_STEPS] + (CORDIC_W'(1) <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
    ang = zr[CORDIC_W-1] ? '0 : zr[COORD_W-1:0];
    rot = zr > CORDIC_W'(EPS_Q);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (x0[CORDIC_W-1]) begin
        cx[0] <= y0;
        cy[0] <= -x0;
        cz[0] <= CORDIC_W'(HALF_PI_Q30);
      end else begin
        cx[0] <= x0;
        cy[0] <= y0;
        cz[0] <= '0;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        cx[i+1] <= nx[i];
        cy[i+1] <= ny[i];
        cz[i+1] <= nz[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register. A rotation at or below the threshold reports a zero axis but
  // still carries its angle.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= vld[LAST_STG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rotation_valid <= rot;
      axis_x <= rot ? cross_d[CROSS_DLY-1][0] : '0;
      axis_y <= rot ? cross_d[CROSS_DLY-1][1] : '0;
      axis_z <= rot ? cross_d[CROSS_DLY-1][2] : '0;
      angle  <= ang;
    end
  end

endmodule

[sv/arcrot_checker.sv]
// ----------------------------------------------------------------------------
// arcrot_checker: port-level checks of the arcball rotation block
// Watches the result channel and the configuration handshake.
// ----------------------------------------------------------------------------
module arcrot_checker import arcrot_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               cfg_ready,
  input logic               result_valid,
  input logic               result_stall,
  input logic               rotation_valid,
  input coord_t             axis_x,
  input coord_t             axis_y,
  input coord_t             axis_z,
  input logic [COORD_W-1:0] angle
);

  // A held result keeps its angle and axis_x.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(angle) && $stable(axis_x))
    else $error("stalled result changed");

  // No rotation means a zero axis.
  a_zero_axis: assert property (@(posedge clk) disable iff (rst)
    result_valid && !rotation_valid |-> axis_x == '0 && axis_y == '0 && axis_z == '0)
    else $error("axis not zero without rotation");

  // A reported rotation exceeds the threshold and never exceeds a half turn.
  a_angle: assert property (@(posedge clk) disable iff (rst)
    result_valid && rotation_valid |-> angle > COORD_W'(EPS_Q) && angle <= 16'd51472)
    else $error("rotation angle out of range");

  // Configuration writes are always taken.
  a_cfg: assert property (@(posedge clk) disable iff (rst) $past(rst) || cfg_ready)
    else $error("configuration port not ready");

endmodule

bind arcball_rotation arcrot_checker u_arcrot_checker (
  .clk            (clk),
  .rst            (rst),
  .cfg_ready      (cfg_ready),
  .result_valid   (result_valid),
  .result_stall   (result_stall),
  .rotation_valid (rotation_valid),
  .axis_x         (axis_x),
  .axis_y         (axis_y),
  .axis_z         (axis_z),
  .angle          (angle)
);
